FILE: design/pabt_pkg.sv
// Package for the peer address binding table.
// Holds sizes, request and outcome codes, and the structs between top and cells.
// No dependencies.
package pabt_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int FUNC_W      = 2;
  localparam int ADDR_W      = 8;
  localparam int MAC_W       = 48;
  localparam int TIME_W      = 32;
  localparam int OUTC_W      = 3;
  localparam int CTR_W       = 32;

  localparam logic [TIME_W-1:0] STALE_RESET = 32'd60000;

  localparam logic [FUNC_W-1:0] FN_RECORD = 2'd0;
  localparam logic [FUNC_W-1:0] FN_LOOKUP = 2'd1;
  localparam logic [FUNC_W-1:0] FN_READ   = 2'd2;

  localparam logic [OUTC_W-1:0] OC_ADDED     = 3'd0;
  localparam logic [OUTC_W-1:0] OC_REFRESHED = 3'd1;
  localparam logic [OUTC_W-1:0] OC_CONFLICT  = 3'd2;
  localparam logic [OUTC_W-1:0] OC_REBOUND   = 3'd3;
  localparam logic [OUTC_W-1:0] OC_FULL      = 3'd4;
  localparam logic [OUTC_W-1:0] OC_HIT       = 3'd5;
  localparam logic [OUTC_W-1:0] OC_MISS      = 3'd6;

  typedef struct packed {
    logic              capture;
    logic [FUNC_W-1:0] func;
    logic [ADDR_W-1:0] key_addr;
    logic [ADDR_W-1:0] key_index;
    logic [CNT_W-1:0]  used_count;
  } look_t;

  typedef struct packed {
    logic              append;
    logic              upd_mac;
    logic              upd_seen;
    logic [CNT_W-1:0]  used_count;
    logic [ADDR_W-1:0] new_addr;
    logic [MAC_W-1:0]  new_mac;
    logic [TIME_W-1:0] new_seen;
  } wr_t;

  typedef struct packed {
    logic              hit_above;
    logic              found;
    logic [ADDR_W-1:0] addr;
    logic [MAC_W-1:0]  mac;
    logic [TIME_W-1:0] seen;
  } link_t;

endpackage

FILE: design/pabt_cell.sv
// One table cell: holds a binding, matches the request key, passes results on.
// Depends on pabt_pkg.
module pabt_cell import pabt_pkg::*; (
  input  logic             clk,
  input  logic [IDX_W-1:0] cell_idx,
  input  look_t            look,
  input  wr_t              wr,
  input  link_t            link_in,
  output link_t            link_out
);

  logic [ADDR_W-1:0] addr_r;
  logic [MAC_W-1:0]  mac_r;
  logic [TIME_W-1:0] seen_r;
  logic              sel_r;
  logic              valid;
  logic              match;
  logic              append_me;

  assign valid     = CNT_W'(cell_idx) < look.used_count;
  assign append_me = wr.append && (CNT_W'(cell_idx) == wr.used_count);

  always_comb begin
    case (look.func)
      FN_RECORD: match = valid && (addr_r == look.key_addr);
      FN_LOOKUP: match = valid && (addr_r == look.key_addr);
      FN_READ:   match = valid && (look.key_index == ADDR_W'(cell_idx));
      default:   match = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (look.capture) begin
      sel_r <= match && !link_in.hit_above;
    end
    if (append_me) begin
      addr_r <= wr.new_addr;
      mac_r  <= wr.new_mac;
      seen_r <= wr.new_seen;
    end else begin
      if (sel_r && wr.upd_mac) begin
        mac_r <= wr.new_mac;
      end
      if (sel_r && wr.upd_seen) begin
        seen_r <= wr.new_seen;
      end
    end
  end

  always_comb begin
    link_out.hit_above = link_in.hit_above | match;
    link_out.found     = link_in.found | sel_r;
    link_out.addr      = link_in.addr | (sel_r ? addr_r : '0);
    link_out.mac       = link_in.mac  | (sel_r ? mac_r  : '0);
    link_out.seen      = link_in.seen | (sel_r ? seen_r : '0);
  end

endmodule

FILE: design/peer_address_binding_table_unit.sv
// Top level of the peer address binding table: control, counters, output register.
// Depends on pabt_pkg and pabt_cell.
//
// Usage:
//   Input channel in_*: one request per transaction (record, lookup, read by
//   index). Output channel out_*: exactly one result transaction per request.
//   cfg_wr_en/cfg_wr_data write the stale limit in ms; write only while idle.
// Operation:
//   When a request is taken, the cell row compares its key in parallel and
//   latches the first matching cell. In the execute state that follows, the
//   selected binding is read down the cell chain; the decide step then
//   updates the cell and loads the output register. No new request is taken
//   until the decide step; the result is valid the cycle after the decide step.
// Reset:
//   Clears the entry count, the drop, conflict and rebind counters and the
//   output valid, and restores the stale limit to 60000 ms. Cell contents are
//   not cleared; cells at or beyond the entry count are never read.
// Stall:
//   While out_stall holds a result, one more request may be taken; its decide
//   step waits until the output register is free. in_stall is high from the
//   acceptance of a request until its decide step.
module peer_address_binding_table_unit import pabt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [TIME_W-1:0] cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [ADDR_W-1:0] in_node_addr,
  input  logic [MAC_W-1:0]  in_mac_in,
  input  logic [TIME_W-1:0] in_now_ms,
  input  logic [ADDR_W-1:0] in_entry_index,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [OUTC_W-1:0] out_outcome,
  output logic [MAC_W-1:0]  out_mac_out,
  output logic              out_add_peer,
  output logic              out_del_peer,
  output logic [ADDR_W-1:0] out_addr_out,
  output logic [TIME_W-1:0] out_last_seen_out,
  output logic [CNT_W-1:0]  out_entry_count,
  output logic [CTR_W-1:0]  out_dropped_count,
  output logic [CTR_W-1:0]  out_conflict_count,
  output logic [CTR_W-1:0]  out_rebind_count
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  logic [TIME_W-1:0] stale_r;
  logic [CNT_W-1:0]  used_r, used_nxt;
  logic [CTR_W-1:0]  drops_r, drops_nxt;
  logic [CTR_W-1:0]  confl_r, confl_nxt;
  logic [CTR_W-1:0]  rebind_r, rebind_nxt;

  logic [FUNC_W-1:0] req_func_r;
  logic [ADDR_W-1:0] req_addr_r;
  logic [MAC_W-1:0]  req_mac_r;
  logic [TIME_W-1:0] req_now_r;

  logic              out_valid_r, out_valid_nxt;
  logic [OUTC_W-1:0] oc_r, oc_nxt;
  logic [MAC_W-1:0]  omac_r, omac_nxt;
  logic              oadd_r, oadd_nxt;
  logic              odel_r, odel_nxt;
  logic [ADDR_W-1:0] oaddr_r, oaddr_nxt;
  logic [TIME_W-1:0] oseen_r, oseen_nxt;

  logic              accept;
  logic              decide;
  logic [TIME_W-1:0] age;
  look_t             look;
  wr_t               wr;
  link_t             links [MAX_ENTRIES+1];
  link_t             sel;

  assign in_stall = !rst_n || (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign decide   = (state_r == S_EXEC) && (!out_valid_r || !out_stall);

  always_comb begin
    look.capture    = accept;
    look.func       = in_func;
    look.key_addr   = in_node_addr;
    look.key_index  = in_entry_index;
    look.used_count = used_r;
  end

  assign links[0] = '0;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    pabt_cell u_cell (
      .clk      (clk),
      .cell_idx (IDX_W'(i)),
      .look     (look),
      .wr       (wr),
      .link_in  (links[i]),
      .link_out (links[i+1])
    );
  end

  assign sel = links[MAX_ENTRIES];
  assign age = req_now_r - sel.seen;

  always_comb begin
    used_nxt      = used_r;
    drops_nxt     = drops_r;
    confl_nxt     = confl_r;
    rebind_nxt    = rebind_r;
    oc_nxt        = OC_MISS;
    omac_nxt      = '0;
    oadd_nxt      = 1'b0;
    odel_nxt      = 1'b0;
    oaddr_nxt     = '0;
    oseen_nxt     = '0;
    wr.append     = 1'b0;
    wr.upd_mac    = 1'b0;
    wr.upd_seen   = 1'b0;
    wr.used_count = used_r;
    wr.new_addr   = req_addr_r;
    wr.new_mac    = req_mac_r;
    wr.new_seen   = req_now_r;
    case (req_func_r)
      FN_RECORD: begin
        if (!sel.found) begin
          if (used_r == CNT_W'(MAX_ENTRIES)) begin
            drops_nxt = drops_r + 1'b1;
            oc_nxt    = OC_FULL;
          end else begin
            wr.append = decide;
            used_nxt  = used_r + 1'b1;
            oc_nxt    = OC_ADDED;
            oadd_nxt  = 1'b1;
          end
        end else if (sel.mac == req_mac_r) begin
          wr.upd_seen = decide;
          oc_nxt      = OC_REFRESHED;
        end else if (age <= stale_r) begin
          confl_nxt = confl_r + 1'b1;
          oc_nxt    = OC_CONFLICT;
        end else begin
          wr.upd_mac  = decide;
          wr.upd_seen = decide;
          rebind_nxt  = rebind_r + 1'b1;
          oc_nxt      = OC_REBOUND;
          omac_nxt    = sel.mac;
          oadd_nxt    = 1'b1;
          odel_nxt    = 1'b1;
        end
      end
      FN_LOOKUP: begin
        if (sel.found) begin
          oc_nxt   = OC_HIT;
          omac_nxt = sel.mac;
        end
      end
      FN_READ: begin
        if (sel.found) begin
          oc_nxt    = OC_HIT;
          omac_nxt  = sel.mac;
          oaddr_nxt = sel.addr;
          oseen_nxt = sel.seen;
        end
      end
      default: begin
        oc_nxt = OC_MISS;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (accept) state_nxt = S_EXEC;
      S_EXEC:  if (decide) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (decide) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      stale_r     <= STALE_RESET;
      used_r      <= '0;
      drops_r     <= '0;
      confl_r     <= '0;
      rebind_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        stale_r <= cfg_wr_data;
      end
      if (decide) begin
        used_r   <= used_nxt;
        drops_r  <= drops_nxt;
        confl_r  <= confl_nxt;
        rebind_r <= rebind_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_func_r <= in_func;
      req_addr_r <= in_node_addr;
      req_mac_r  <= in_mac_in;
      req_now_r  <= in_now_ms;
    end
    if (decide) begin
      oc_r    <= oc_nxt;
      omac_r  <= omac_nxt;
      oadd_r  <= oadd_nxt;
      odel_r  <= odel_nxt;
      oaddr_r <= oaddr_nxt;
      oseen_r <= oseen_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_outcome        = oc_r;
  assign out_mac_out        = omac_r;
  assign out_add_peer       = oadd_r;
  assign out_del_peer       = odel_r;
  assign out_addr_out       = oaddr_r;
  assign out_last_seen_out  = oseen_r;
  assign out_entry_count    = used_r;
  assign out_dropped_count  = drops_r;
  assign out_conflict_count = confl_r;
  assign out_rebind_count   = rebind_r;

  a_rise_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EXEC))
    else $error("result raised without a decide step");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNT_W'(MAX_ENTRIES))
    else $error("entry count beyond table size");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_EXEC)
    else $error("accepted transaction not executed");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    decide |=> (used_r == $past(used_r)) || (used_r == $past(used_r) + 1'b1))
    else $error("entry count moved by more than one");

endmodule

FILE: sim/tb_peer_address_binding_table_unit.sv
// Testbench for peer_address_binding_table_unit: random and directed requests on
// the valid/stall channels, predicted in order, checked field by field.
// Depends on pabt_pkg and the RTL of peer_address_binding_table_unit.
`timescale 1ns / 1ps

module tb_peer_address_binding_table_unit;
  import pabt_pkg::*;

  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 200;
  localparam int POOL_SIZE   = 24;
  localparam int POOL_W      = $clog2(POOL_SIZE);
  localparam int PHASES      = 7;
  localparam int PHASE_W     = $clog2(PHASES);

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ADDR_W-1:0] node_addr;
    logic [MAC_W-1:0]  mac;
    logic [TIME_W-1:0] now_ms;
    logic [ADDR_W-1:0] entry_index;
  } bind_req_t;

  typedef struct packed {
    logic [OUTC_W-1:0] outcome;
    logic [MAC_W-1:0]  mac;
    logic              add_peer;
    logic              del_peer;
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] last_seen;
    logic [CNT_W-1:0]  count;
    logic [CTR_W-1:0]  drops;
    logic [CTR_W-1:0]  conflicts;
    logic [CTR_W-1:0]  rebinds;
  } bind_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [TIME_W-1:0] cfg_wr_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [FUNC_W-1:0] in_func = '0;
  logic [ADDR_W-1:0] in_node_addr = '0;
  logic [MAC_W-1:0]  in_mac_in = '0;
  logic [TIME_W-1:0] in_now_ms = '0;
  logic [ADDR_W-1:0] in_entry_index = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [OUTC_W-1:0] out_outcome;
  logic [MAC_W-1:0]  out_mac_out;
  logic              out_add_peer;
  logic              out_del_peer;
  logic [ADDR_W-1:0] out_addr_out;
  logic [TIME_W-1:0] out_last_seen_out;
  logic [CNT_W-1:0]  out_entry_count;
  logic [CTR_W-1:0]  out_dropped_count;
  logic [CTR_W-1:0]  out_conflict_count;
  logic [CTR_W-1:0]  out_rebind_count;

  peer_address_binding_table_unit i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_func            (in_func),
    .in_node_addr       (in_node_addr),
    .in_mac_in          (in_mac_in),
    .in_now_ms          (in_now_ms),
    .in_entry_index     (in_entry_index),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_outcome        (out_outcome),
    .out_mac_out        (out_mac_out),
    .out_add_peer       (out_add_peer),
    .out_del_peer       (out_del_peer),
    .out_addr_out       (out_addr_out),
    .out_last_seen_out  (out_last_seen_out),
    .out_entry_count    (out_entry_count),
    .out_dropped_count  (out_dropped_count),
    .out_conflict_count (out_conflict_count),
    .out_rebind_count   (out_rebind_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Binding table shadow
  logic [ADDR_W-1:0] tbl_addr [MAX_ENTRIES];
  logic [MAC_W-1:0]  tbl_mac  [MAX_ENTRIES];
  logic [TIME_W-1:0] tbl_seen [MAX_ENTRIES];
  int                tbl_used = 0;
  logic [CTR_W-1:0]  n_drops = '0;
  logic [CTR_W-1:0]  n_conflicts = '0;
  logic [CTR_W-1:0]  n_rebinds = '0;
  logic [TIME_W-1:0] stale_limit = STALE_RESET;

  bind_req_t    pending_reqs[$];
  bind_result_t expected_results[$];
  bind_req_t    cur_req;
  bind_result_t want;
  int           issued_total = 0;
  int           results_seen = 0;
  int           mismatch_count = 0;
  int           gap_left = 0;
  int           stall_left = 0;
  int           cycle_count = 0;
  bit           slot_free;
  logic         src_gaps_on = 1'b1;
  logic         rcv_stalls_on = 1'b1;
  logic         hold_request = 1'b0;

  logic [ADDR_W-1:0] addr_pool [POOL_SIZE];
  logic [MAC_W-1:0]  mac_base  [256];
  logic [TIME_W-1:0] clock_ms;

  function automatic bind_result_t resolve_request(bind_req_t rq);
    bind_result_t r;
    int slot;
    logic [TIME_W-1:0] age;
    r = '0;
    r.outcome = OC_MISS;
    slot = -1;
    for (int i = 0; i < tbl_used; i++)
      if (slot < 0 && tbl_addr[IDX_W'(i)] == rq.node_addr) slot = i;
    case (rq.func)
      FN_RECORD: begin
        if (slot < 0) begin
          if (tbl_used >= MAX_ENTRIES) begin
            n_drops = n_drops + 1'b1;
            r.outcome = OC_FULL;
          end else begin
            tbl_addr[IDX_W'(tbl_used)] = rq.node_addr;
            tbl_mac[IDX_W'(tbl_used)] = rq.mac;
            tbl_seen[IDX_W'(tbl_used)] = rq.now_ms;
            tbl_used++;
            r.outcome = OC_ADDED;
            r.add_peer = 1'b1;
          end
        end else if (tbl_mac[IDX_W'(slot)] == rq.mac) begin
          tbl_seen[IDX_W'(slot)] = rq.now_ms;
          r.outcome = OC_REFRESHED;
        end else begin
          age = rq.now_ms - tbl_seen[IDX_W'(slot)];
          if (age <= stale_limit) begin
            n_conflicts = n_conflicts + 1'b1;
            r.outcome = OC_CONFLICT;
          end else begin
            r.mac = tbl_mac[IDX_W'(slot)];
            tbl_mac[IDX_W'(slot)] = rq.mac;
            tbl_seen[IDX_W'(slot)] = rq.now_ms;
            n_rebinds = n_rebinds + 1'b1;
            r.outcome = OC_REBOUND;
            r.add_peer = 1'b1;
            r.del_peer = 1'b1;
          end
        end
      end
      FN_LOOKUP: begin
        if (slot >= 0) begin
          r.outcome = OC_HIT;
          r.mac = tbl_mac[IDX_W'(slot)];
        end
      end
      FN_READ: begin
        if (int'(rq.entry_index) < tbl_used) begin
          r.outcome = OC_HIT;
          r.mac = tbl_mac[IDX_W'(rq.entry_index)];
          r.addr = tbl_addr[IDX_W'(rq.entry_index)];
          r.last_seen = tbl_seen[IDX_W'(rq.entry_index)];
        end
      end
      default: ;
    endcase
    r.count = CNT_W'(tbl_used);
    r.drops = n_drops;
    r.conflicts = n_conflicts;
    r.rebinds = n_rebinds;
    return r;
  endfunction

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [MAC_W-1:0] rand_mac();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic bind_req_t make_req(logic [FUNC_W-1:0] f, logic [ADDR_W-1:0] a,
                                         logic [MAC_W-1:0] m, logic [TIME_W-1:0] t,
                                         logic [ADDR_W-1:0] idx);
    bind_req_t rq;
    rq.func = f;
    rq.node_addr = a;
    rq.mac = m;
    rq.now_ms = t;
    rq.entry_index = idx;
    return rq;
  endfunction

  function automatic bind_req_t random_request();
    bind_req_t rq;
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) clock_ms = clock_ms + $urandom_range(0, 200);
    else if (r < 90) clock_ms = clock_ms + $urandom_range(0, 70000);
    else if (r < 97) clock_ms = clock_ms + $urandom;
    rq.now_ms = (r >= 97) ? TIME_W'($urandom) : clock_ms;
    rq.node_addr = ($urandom_range(0, 99) < 85)
                   ? addr_pool[POOL_W'($urandom_range(0, POOL_SIZE - 1))]
                   : ADDR_W'($urandom);
    rq.mac = rand_mac();
    rq.entry_index = ADDR_W'($urandom);
    r = $urandom_range(0, 99);
    if (r < 55) begin
      rq.func = FN_RECORD;
      if ($urandom_range(0, 99) < 80)
        rq.mac = mac_base[rq.node_addr] ^ MAC_W'($urandom_range(0, 1));
    end else if (r < 75) begin
      rq.func = FN_LOOKUP;
    end else if (r < 95) begin
      rq.func = FN_READ;
      if ($urandom_range(0, 99) < 80)
        rq.entry_index = ADDR_W'($urandom_range(0, MAX_ENTRIES + 1));
    end else begin
      rq.func = FN_UNUSED;
    end
    return rq;
  endfunction

  task automatic queue_request(bind_req_t rq);
    pending_reqs.push_back(rq);
    issued_total++;
  endtask

  task automatic wait_drained();
    while (results_seen != issued_total) @(posedge clk);
  endtask

  task automatic write_stale(logic [TIME_W-1:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    stale_limit = value;
  endtask

  task automatic check_field(string field, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: %s expected %0h got %0h", $time, field, exp_v, act_v);
    end
  endtask

  // Input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      slot_free = !in_valid || !in_stall;
      if (in_valid && !in_stall) begin
        expected_results.push_back(resolve_request(cur_req));
        if (src_gaps_on) gap_left = pick_idle();
      end
      if (slot_free) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          cur_req = pending_reqs.pop_front();
          in_func <= cur_req.func;
          in_node_addr <= cur_req.node_addr;
          in_mac_in <= cur_req.mac;
          in_now_ms <= cur_req.now_ms;
          in_entry_index <= cur_req.entry_index;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (hold_request) begin
      out_stall <= 1'b1;
      stall_left = HOLD_CYCLES;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (rcv_stalls_on && $urandom_range(0, 99) < 30) begin
      out_stall <= 1'b1;
      stall_left = pick_idle();
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result transaction with no request outstanding", $time);
      end else begin
        want = expected_results.pop_front();
        check_field("outcome", 64'(want.outcome), 64'(out_outcome));
        check_field("mac_out", 64'(want.mac), 64'(out_mac_out));
        check_field("add_peer", 64'(want.add_peer), 64'(out_add_peer));
        check_field("del_peer", 64'(want.del_peer), 64'(out_del_peer));
        check_field("addr_out", 64'(want.addr), 64'(out_addr_out));
        check_field("last_seen_out", 64'(want.last_seen), 64'(out_last_seen_out));
        check_field("entry_count", 64'(want.count), 64'(out_entry_count));
        check_field("dropped_count", 64'(want.drops), 64'(out_dropped_count));
        check_field("conflict_count", 64'(want.conflicts), 64'(out_conflict_count));
        check_field("rebind_count", 64'(want.rebinds), 64'(out_rebind_count));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [TIME_W-1:0] stale_set [PHASES];
    foreach (addr_pool[i]) addr_pool[i] = ADDR_W'($urandom);
    foreach (mac_base[i]) mac_base[i] = rand_mac();
    stale_set[0] = 32'd0;
    stale_set[1] = 32'hFFFF_FFFF;
    stale_set[2] = 32'd1000;
    stale_set[3] = 32'd60000;
    stale_set[4] = $urandom;
    stale_set[5] = 32'd1;
    stale_set[6] = $urandom_range(0, 5000);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    queue_request(make_req(FN_READ,   8'h00, '0, '0, 8'h00));
    queue_request(make_req(FN_LOOKUP, 8'h00, '0, '0, 8'h00));
    queue_request(make_req(FN_UNUSED, 8'hFF, '1, '1, 8'hFF));
    queue_request(make_req(FN_RECORD, 8'h00, '0, 32'd0, 8'h00));
    queue_request(make_req(FN_RECORD, 8'hFF, '1, 32'hFFFF_FFFF, 8'hFF));
    queue_request(make_req(FN_RECORD, 8'h00, '0, 32'd100, 8'h00));
    queue_request(make_req(FN_RECORD, 8'h00, 48'd1, 32'd200, 8'h00));
    queue_request(make_req(FN_RECORD, 8'h00, 48'd1, 32'd60101, 8'h00));
    queue_request(make_req(FN_RECORD, 8'h00, 48'd2, 32'd120101, 8'h00));
    queue_request(make_req(FN_RECORD, 8'hFF, 48'd5, 32'd59999, 8'h00));
    queue_request(make_req(FN_RECORD, 8'hFF, 48'd5, 32'd60000, 8'h00));
    queue_request(make_req(FN_LOOKUP, 8'h00, '0, '0, 8'h00));
    queue_request(make_req(FN_LOOKUP, 8'hFF, '0, '0, 8'h00));
    queue_request(make_req(FN_LOOKUP, 8'h07, '0, '0, 8'h00));
    queue_request(make_req(FN_READ,   8'h00, '0, '0, 8'h01));
    queue_request(make_req(FN_READ,   8'h00, '0, '0, 8'h02));
    queue_request(make_req(FN_READ,   8'h00, '0, '0, 8'hFF));
    queue_request(make_req(FN_READ,   8'h00, '0, '0, 8'h00));
    clock_ms = 32'd200000;

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      write_stale(stale_set[PHASE_W'(p)]);
      src_gaps_on <= (p != 2 && p != 4);
      rcv_stalls_on <= (p != 2);
      if (p == 5) clock_ms = 32'hFFFF_F000;
      for (int n = 0; n < PHASE_ITEMS; n++) queue_request(random_request());
      if (p == 4) begin
        @(posedge clk);
        hold_request <= 1'b1;
        @(posedge clk);
        hold_request <= 1'b0;
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
